>>> design/fqss_pkg.sv
// Shared types, constants and helpers for the FASTQ stanza statistics counter.
// Used by every module of the block; depends on nothing.

package fqss_pkg;

  // Counter width inside the block and width of each count on the result bus
  localparam int unsigned CountWidth = 48;
  localparam int unsigned OutWidth   = 48;

  // Queue between front and back
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  // Character codes
  localparam logic [7:0] ChNewline = 8'h0a;
  localparam logic [7:0] ChPlus    = 8'h2b;
  localparam logic [7:0] ChAt      = 8'h40;
  localparam logic [7:0] ChGzip    = 8'h1f;
  localparam logic [8:0] PhredBase = 9'd33;

  localparam logic [6:0] ThresholdReset = 7'd30;

  // Register map (register index)
  localparam logic RegQualityThreshold = 1'b0;

  typedef enum logic [2:0] {
    StOk         = 3'd0,
    StBadFirst   = 3'd1,
    StGzip       = 3'd2,
    StNoPlus     = 3'd3,
    StIncomplete = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    BaseOther = 2'd0,
    BaseGc    = 2'd1,
    BaseAt    = 2'd2,
    BaseN     = 2'd3
  } base_e;

  // One classified byte as it travels from front to back
  typedef struct packed {
    logic  eos;
    logic  is_nl;
    logic  is_plus;
    logic  is_at;
    logic  is_gzip;
    logic  high_q;
    base_e base;
  } item_t;

  // Queue occupancy flags
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  typedef struct packed {
    logic [OutWidth-1:0] n_count;
    logic [OutWidth-1:0] at_count;
    logic [OutWidth-1:0] gc_count;
    logic [OutWidth-1:0] high_quality_count;
    logic [OutWidth-1:0] base_count;
    logic [OutWidth-1:0] read_count;
    status_e             status;
  } result_t;

  localparam int unsigned ResultBits = $bits(result_t);
  localparam int unsigned OutBytes   = (ResultBits + 7) / 8;
  localparam int unsigned OutDataW   = OutBytes * 8;

  // Fit a counter onto the result width (zero-extend or truncate)
  function automatic logic [OutWidth-1:0] to_out(input logic [CountWidth-1:0] c);
    logic [OutWidth+CountWidth-1:0] ext;
    ext = {{OutWidth{1'b0}}, c};
    return ext[OutWidth-1:0];
  endfunction

  // Saturating increment
  function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] c);
    return (&c) ? c : c + CountWidth'(1);
  endfunction

endpackage

>>> design/fqss_front.sv
// Input stage: accepts stream bytes and classifies them into item_t.
// Depends on fqss_pkg.

module fqss_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 end_of_stream_i,
  input  logic [6:0]           threshold_i,
  input  logic                 fifo_full_i,
  output logic                 push_o,
  output fqss_pkg::item_t      item_o
);

  logic            vld_q, vld_d;
  fqss_pkg::item_t item_q, item_d;
  logic [7:0]      upper;
  logic [8:0]      qmin;

  // Classify the incoming byte
  always_comb begin
    upper = (data_byte_i >= 8'h61 && data_byte_i <= 8'h7a) ? (data_byte_i & 8'hdf)
                                                            : data_byte_i;
    qmin  = {2'b00, threshold_i} + fqss_pkg::PhredBase;

    item_d.eos     = end_of_stream_i;
    item_d.is_nl   = (data_byte_i == fqss_pkg::ChNewline);
    item_d.is_plus = (data_byte_i == fqss_pkg::ChPlus);
    item_d.is_at   = (data_byte_i == fqss_pkg::ChAt);
    item_d.is_gzip = (data_byte_i == fqss_pkg::ChGzip);
    item_d.high_q  = ({1'b0, data_byte_i} >= qmin);
    case (upper)
      8'h47, 8'h43: item_d.base = fqss_pkg::BaseGc;  // G, C
      8'h41, 8'h54: item_d.base = fqss_pkg::BaseAt;  // A, T
      8'h4e:        item_d.base = fqss_pkg::BaseN;   // N
      default:      item_d.base = fqss_pkg::BaseOther;
    endcase
  end

  assign push_o     = vld_q && !fifo_full_i;
  assign in_ready_o = !vld_q || !fifo_full_i;
  assign item_o     = item_q;

  always_comb begin
    vld_d = vld_q;
    if (in_valid_i && in_ready_o) begin
      vld_d = 1'b1;
    end else if (push_o) begin
      vld_d = 1'b0;
    end
  end

  // Stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

>>> design/fqss_fifo.sv
// Short queue of classified items between the front and back stages.
// Depends on fqss_pkg.

module fqss_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  fqss_pkg::item_t        push_item_i,
  input  logic                   pop_i,
  output fqss_pkg::item_t        pop_item_o,
  output fqss_pkg::fifo_status_t status_o
);

  fqss_pkg::item_t               mem_q [fqss_pkg::FifoDepth];
  logic [fqss_pkg::FifoAw-1:0]   wr_ptr_q, wr_ptr_d;
  logic [fqss_pkg::FifoAw-1:0]   rd_ptr_q, rd_ptr_d;
  logic [fqss_pkg::FifoAw:0]     cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == (fqss_pkg::FifoAw+1)'(fqss_pkg::FifoDepth));
  assign status_o.empty = (cnt_q == '0);
  assign pop_item_o     = mem_q[rd_ptr_q];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == fqss_pkg::FifoAw'(fqss_pkg::FifoDepth - 1)) ? '0
                 : wr_ptr_q + fqss_pkg::FifoAw'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == fqss_pkg::FifoAw'(fqss_pkg::FifoDepth - 1)) ? '0
                 : rd_ptr_q + fqss_pkg::FifoAw'(1);
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + (fqss_pkg::FifoAw+1)'(1);
      2'b01:   cnt_d = cnt_q - (fqss_pkg::FifoAw+1)'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

>>> design/fqss_back.sv
// Back stage: stanza tracking, saturating counters and the result register.
// Depends on fqss_pkg.

module fqss_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  fqss_pkg::fifo_status_t fifo_status_i,
  input  fqss_pkg::item_t        item_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output fqss_pkg::result_t      result_o
);

  localparam int unsigned CW = fqss_pkg::CountWidth;

  logic [1:0]        line_q, line_d;
  logic              start_q, start_d;
  logic              first_q, first_d;
  logic              plus_pend_q, plus_pend_d;
  fqss_pkg::status_e status_q, status_d;
  logic [CW-1:0]     reads_q, reads_d, bases_q, bases_d, hq_q, hq_d;
  logic [CW-1:0]     gc_q, gc_d, at_q, at_d, n_q, n_d;
  logic              out_vld_q, out_vld_d;
  fqss_pkg::result_t res_q, res_d;
  fqss_pkg::status_e end_status;
  logic              load_res;

  // An end item waits only while the result register is still occupied
  assign pop_o       = !fifo_status_i.empty && (!item_i.eos || !out_vld_q || out_ready_i);
  assign load_res    = pop_o && item_i.eos;
  assign out_valid_o = out_vld_q;
  assign result_o    = res_q;

  // Status reported at end of stream
  always_comb begin
    end_status = status_q;
    if (status_q == fqss_pkg::StOk) begin
      if (!first_q) begin
        end_status = fqss_pkg::StBadFirst;
      end else if (!((line_q == 2'd0 && start_q) || (line_q == 2'd3 && !start_q))) begin
        end_status = fqss_pkg::StIncomplete;
      end
    end
  end

  // Per-byte state update
  always_comb begin
    line_d      = line_q;
    start_d     = start_q;
    first_d     = first_q;
    plus_pend_d = plus_pend_q;
    status_d    = status_q;
    reads_d     = reads_q;
    bases_d     = bases_q;
    hq_d        = hq_q;
    gc_d        = gc_q;
    at_d        = at_q;
    n_d         = n_q;
    if (pop_o) begin
      if (item_i.eos) begin
        line_d      = 2'd0;
        start_d     = 1'b1;
        first_d     = 1'b0;
        plus_pend_d = 1'b0;
        status_d    = fqss_pkg::StOk;
        reads_d     = '0;
        bases_d     = '0;
        hq_d        = '0;
        gc_d        = '0;
        at_d        = '0;
        n_d         = '0;
      end else if (status_q == fqss_pkg::StOk) begin
        first_d = 1'b1;
        if (!first_q && !item_i.is_at) begin
          status_d = item_i.is_gzip ? fqss_pkg::StGzip : fqss_pkg::StBadFirst;
        end else if (line_q == 2'd3 && start_q && plus_pend_q) begin
          status_d = fqss_pkg::StNoPlus;
        end else begin
          if (line_q == 2'd0 && start_q) begin
            reads_d = fqss_pkg::sat_inc(reads_q);
          end
          if (line_q == 2'd2 && start_q) begin
            plus_pend_d = !item_i.is_plus;
          end
          if (item_i.is_nl) begin
            line_d  = line_q + 2'd1;
            start_d = 1'b1;
          end else begin
            start_d = 1'b0;
            if (line_q == 2'd1) begin
              case (item_i.base)
                fqss_pkg::BaseGc: gc_d = fqss_pkg::sat_inc(gc_q);
                fqss_pkg::BaseAt: at_d = fqss_pkg::sat_inc(at_q);
                fqss_pkg::BaseN:  n_d  = fqss_pkg::sat_inc(n_q);
                default:          gc_d = gc_q;
              endcase
            end else if (line_q == 2'd3) begin
              bases_d = fqss_pkg::sat_inc(bases_q);
              if (item_i.high_q) begin
                hq_d = fqss_pkg::sat_inc(hq_q);
              end
            end
          end
        end
      end
    end
  end

  // Result register
  always_comb begin
    out_vld_d = out_vld_q;
    if (load_res) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
    res_d.status             = end_status;
    res_d.read_count         = fqss_pkg::to_out(reads_q);
    res_d.base_count         = fqss_pkg::to_out(bases_q);
    res_d.high_quality_count = fqss_pkg::to_out(hq_q);
    res_d.gc_count           = fqss_pkg::to_out(gc_q);
    res_d.at_count           = fqss_pkg::to_out(at_q);
    res_d.n_count            = fqss_pkg::to_out(n_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q      <= 2'd0;
      start_q     <= 1'b1;
      first_q     <= 1'b0;
      plus_pend_q <= 1'b0;
      status_q    <= fqss_pkg::StOk;
      reads_q     <= '0;
      bases_q     <= '0;
      hq_q        <= '0;
      gc_q        <= '0;
      at_q        <= '0;
      n_q         <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      line_q      <= line_d;
      start_q     <= start_d;
      first_q     <= first_d;
      plus_pend_q <= plus_pend_d;
      status_q    <= status_d;
      reads_q     <= reads_d;
      bases_q     <= bases_d;
      hq_q        <= hq_d;
      gc_q        <= gc_d;
      at_q        <= at_d;
      n_q         <= n_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      res_q <= res_d;
    end
  end

endmodule

>>> design/fastq_stanza_stats_counter.sv
// Top level of the FASTQ stanza statistics counter: config register, front,
// queue and back stages. Depends on fqss_pkg, fqss_front, fqss_fifo, fqss_back.
//
//  Channel   Direction  Content
//  s_axis    in         tdata[7:0] data_byte, tlast end_of_stream
//  m_axis    out        tdata status, read/base/high_quality/gc/at/n counts
//  apb       in/out     reg 0 at 0x0: quality_threshold[6:0]
//
// One byte per cycle is accepted and counted unless a stalled output backs up the queue;
// m_axis_tvalid is set once end of stream passes front register, queue, result register.
// Reset clears all counters and stanza state; quality_threshold resets to 30.
// A stalled result output holds the next end-of-stream transaction at the queue
// head, and every byte behind it waits; bytes ahead of it keep flowing.
// Input backs up once the queue and the front register are both full.

module fastq_stanza_stats_counter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // stream in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
  input  logic                          s_axis_tlast,  // end_of_stream
  // stream out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [2:0] status, [50:3] read_count, [98:51] base_count,
  // [146:99] high_quality_count, [194:147] gc_count, [242:195] at_count,
  // [290:243] n_count, rest zero
  output logic [fqss_pkg::OutDataW-1:0] m_axis_tdata,
  // config
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic                   fifo_push, fifo_pop;
  fqss_pkg::item_t        front_item, back_item;
  fqss_pkg::fifo_status_t fifo_st;
  fqss_pkg::result_t      result;
  logic [6:0]             thr_q, thr_d;
  logic                   reg_sel;

  // Config register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == fqss_pkg::RegQualityThreshold);
  assign prdata  = reg_sel ? {25'd0, thr_q} : 32'd0;

  always_comb begin
    thr_d = thr_q;
    if (psel && penable && pwrite && pready && reg_sel) begin
      thr_d = pwdata[6:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= fqss_pkg::ThresholdReset;
    end else begin
      thr_q <= thr_d;
    end
  end

  fqss_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .data_byte_i     (s_axis_tdata),
    .end_of_stream_i (s_axis_tlast),
    .threshold_i     (thr_q),
    .fifo_full_i     (fifo_st.full),
    .push_o          (fifo_push),
    .item_o          (front_item)
  );

  fqss_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fifo_push),
    .push_item_i (front_item),
    .pop_i       (fifo_pop),
    .pop_item_o  (back_item),
    .status_o    (fifo_st)
  );

  fqss_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fifo_status_i (fifo_st),
    .item_i        (back_item),
    .pop_o         (fifo_pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .result_o      (result)
  );

  assign m_axis_tdata = {(fqss_pkg::OutDataW - fqss_pkg::ResultBits)'(0), result};

  // Queue flags are never both set
  a_fifo_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_st.full && fifo_st.empty))
    else $error("queue full and empty at once");

  // No push into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push |-> !fifo_st.full)
    else $error("push into full queue");

  // No pop from an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop |-> !fifo_st.empty)
    else $error("pop from empty queue");

  // Reported status is always a defined code
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2:0] <= 3'(fqss_pkg::StIncomplete)))
    else $error("undefined status code on output");

endmodule
